// ===== hw/rtl/iec_pkg.sv =====
// ----------------------------------------------------------------------------
// iec_pkg: shared types and constants of the IOPMP error capture unit
// Transfer structs for both channels, opcodes, register indexes, ttype map.
// ----------------------------------------------------------------------------
package iec_pkg;

  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [15:0] EntryIdNone   = 16'hFFFF;
  localparam int unsigned AddrLowShift  = 2;
  localparam int unsigned AddrHighShift = 34;

  typedef enum logic [1:0] {
    OP_VIOLATION = 2'd0,
    OP_CLEAR_MSI = 2'd1,
    OP_CLEAR_REC = 2'd2,
    OP_NONE      = 2'd3
  } opcode_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_IRQ_ENABLE       = 8'd0,
    REG_MSI_SELECT       = 8'd1,
    REG_MSI_SUPPORTED    = 8'd2,
    REG_MSI_INJECT_WERR  = 8'd3,
    REG_NO_ERROR_RECORD  = 8'd4,
    REG_MULTIFAULT_EN    = 8'd5,
    REG_ADDR_HIGH_EN     = 8'd6,
    REG_ENTRY_ID_DISABLE = 8'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TXN_READ   = 2'd0,
    TXN_WRITE  = 2'd1,
    TXN_ATOMIC = 2'd2,
    TXN_EXEC   = 2'd3
  } txn_kind_t;

  localparam logic [1:0] TTYPE_READ  = 2'd1;
  localparam logic [1:0] TTYPE_WRITE = 2'd2;
  localparam logic [1:0] TTYPE_EXEC  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] requester_id;
    logic [63:0] byte_address;
    logic [1:0]  txn_kind;
    logic [3:0]  error_type;
    logic        entry_matched;
    logic [15:0] entry_index;
    logic [31:0] user_word;
    logic        suppress_irq;
  } in_item_t;

  typedef struct packed {
    logic        record_valid;
    logic [1:0]  rec_ttype;
    logic [3:0]  rec_etype;
    logic        msi_write_error;
    logic        subsequent_seen;
    logic [31:0] req_word_addr_low;
    logic [29:0] req_word_addr_high;
    logic [15:0] rec_requester;
    logic [15:0] rec_entry_id;
    logic [31:0] rec_user_word;
    logic        irq_pending;
    logic        msi_pending;
  } out_item_t;

  function automatic logic [1:0] map_ttype(input logic [1:0] kind);
    logic [1:0] t;
    unique case (txn_kind_t'(kind))
      TXN_READ:   t = TTYPE_READ;
      TXN_WRITE:  t = TTYPE_WRITE;
      TXN_ATOMIC: t = TTYPE_WRITE;
      TXN_EXEC:   t = TTYPE_EXEC;
      default:    t = TTYPE_EXEC;
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/iopmp_error_capture_top.sv =====
// ----------------------------------------------------------------------------
// iopmp_error_capture_top: fault capture unit of an IOPMP checker
// First violation wins the error record; later ones mark the multi-fault
// bitmap when enabled. Each transfer returns the record state after its update.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+-----------------------------------
//  in      | input     | in_valid/in_stall | in_data  (iec_pkg::in_item_t)
//  out     | output    | out_valid/stall   | out_data (iec_pkg::out_item_t)
//  cfg     | input     | cfg_valid/ready   | cfg_index, cfg_data (bit 0 used)
//
//  Transfers: one transfer per cycle in while in_stall is low, one result per
//    transfer out; each result is registered in the output or skid register.
//  The record update is a single pass of logic from the record registers
//    back into them, so back-to-back transfers see each other's effect.
//  Stalls: a two-entry output buffer (output register plus skid register)
//    absorbs one stalled result; in_stall is raised only while the skid holds.
//  Reset (rst, synchronous): clears configuration, the record, the flags
//    and the multi-fault bitmap; cfg_ready is always high.
//
module iopmp_error_capture_top #(
  parameter int unsigned REQUESTER_COUNT = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  iec_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output iec_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iec_pkg::CfgIndexW-1:0]        cfg_index,
  input  logic [iec_pkg::CfgDataW-1:0]         cfg_data
);
  import iec_pkg::*;

  localparam int unsigned IdxW = (REQUESTER_COUNT > 1) ? $clog2(REQUESTER_COUNT) : 1;
  localparam logic [16:0] ReqLimit = 17'(REQUESTER_COUNT);

  // configuration bits
  logic irq_enable, msi_select, msi_supported, msi_inject_write_error;
  logic no_error_record, multifault_enable, addr_high_enable, entry_id_disable;

  // error record and flags
  out_item_t            rec;
  out_item_t            rec_next;
  logic [REQUESTER_COUNT-1:0] fault_bitmap;
  logic [REQUESTER_COUNT-1:0] fault_bitmap_next;

  // output buffer
  out_item_t skid_data;
  logic      skid_valid;

  logic in_take, out_take, cfg_take;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_stall  = skid_valid;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Configuration writes: bit 0 of the data sets the addressed flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enable             <= 1'b0;
      msi_select             <= 1'b0;
      msi_supported          <= 1'b0;
      msi_inject_write_error <= 1'b0;
      no_error_record        <= 1'b0;
      multifault_enable      <= 1'b0;
      addr_high_enable       <= 1'b0;
      entry_id_disable       <= 1'b0;
    end else if (cfg_take) begin
      unique case (cfg_index)
        REG_IRQ_ENABLE:       irq_enable             <= cfg_data[0];
        REG_MSI_SELECT:       msi_select             <= cfg_data[0];
        REG_MSI_SUPPORTED:    msi_supported          <= cfg_data[0];
        REG_MSI_INJECT_WERR:  msi_inject_write_error <= cfg_data[0];
        REG_NO_ERROR_RECORD:  no_error_record        <= cfg_data[0];
        REG_MULTIFAULT_EN:    multifault_enable      <= cfg_data[0];
        REG_ADDR_HIGH_EN:     addr_high_enable       <= cfg_data[0];
        REG_ENTRY_ID_DISABLE: entry_id_disable       <= cfg_data[0];
        default: ; // drop writes past the register list
      endcase
    end
  end

  // Record update for one transfer.
  always_comb begin
    rec_next          = rec;
    fault_bitmap_next = fault_bitmap;
    unique case (opcode_t'(in_data.opcode))
      OP_VIOLATION: begin
        if (!no_error_record) begin
          if (rec.record_valid) begin
            // Record already held: if multi-fault is enabled and the ID is in range, log it and set svc.
            if (multifault_enable && ({1'b0, in_data.requester_id} < ReqLimit)) begin
              fault_bitmap_next[in_data.requester_id[IdxW-1:0]] = 1'b1;
              rec_next.subsequent_seen = 1'b1;
            end
          end else begin
            rec_next.record_valid      = 1'b1;
            rec_next.rec_ttype         = map_ttype(in_data.txn_kind);
            rec_next.rec_etype         = in_data.error_type;
            rec_next.msi_write_error   = 1'b0;
            rec_next.subsequent_seen   = 1'b0;
            rec_next.req_word_addr_low = in_data.byte_address[AddrLowShift +: 32];
            if (addr_high_enable) begin
              rec_next.req_word_addr_high = in_data.byte_address[AddrHighShift +: 30];
            end
            rec_next.rec_requester = in_data.requester_id;
            rec_next.rec_entry_id  = (entry_id_disable || !in_data.entry_matched)
                                     ? EntryIdNone : in_data.entry_index;
            if (in_data.entry_matched) begin
              rec_next.rec_user_word = in_data.user_word;
            end
            // Deliver the interrupt: MSI when selected and supported, else wired.
            if (!in_data.suppress_irq && irq_enable) begin
              if (msi_supported && msi_select) begin
                rec_next.msi_pending = 1'b1;
                if (msi_inject_write_error) begin
                  rec_next.msi_write_error = 1'b1;
                end
              end else begin
                rec_next.irq_pending = 1'b1;
              end
            end
          end
        end
      end
      OP_CLEAR_MSI: rec_next.msi_pending = 1'b0;
      OP_CLEAR_REC: begin
        // Keep the other record fields and svc.
        rec_next.record_valid = 1'b0;
        rec_next.irq_pending  = 1'b0;
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec          <= '0;
      fault_bitmap <= '0;
    end else if (in_take) begin
      rec          <= rec_next;
      fault_bitmap <= fault_bitmap_next;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (in_take) begin
        if (!out_valid || out_take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (in_take) begin
      if (!out_valid || out_take) begin
        out_data <= rec_next;
      end else begin
        skid_data <= rec_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a valid output");

  a_first_capture: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_data.opcode == OP_VIOLATION && !no_error_record && !rec.record_valid)
    |=> rec.record_valid)
    else $error("violation on empty record was not captured");

  a_clear_record: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_data.opcode == OP_CLEAR_REC) |=> (!rec.record_valid && !rec.irq_pending))
    else $error("clear record left valid or wired interrupt set");

  a_svc_needs_record: assert property (@(posedge clk) disable iff (rst)
    $rose(rec.subsequent_seen) |-> $past(rec.record_valid))
    else $error("svc set without a held record");

  a_stall_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !skid_valid && in_take) |=> skid_valid)
    else $error("stalled result not kept in skid entry");
`endif

endmodule
